/* hdl/cfbsx_pkg.sv */
// ----------------------------------------------------------------------------
// cfbsx_pkg: shared types and constants of the command frame builder
// Holds the frame constants, the input action codes and the command record
// that travels from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package cfbsx_pkg;

    // Fixed frame bytes
    localparam logic [7:0] FRAME_HEAD = 8'h79;
    localparam logic [7:0] FRAME_MARK = 8'h58;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // Command record: a frame start or one payload byte
    typedef struct packed {
        logic        is_start;  // 1 = start frame, 0 = payload byte
        logic        last;      // payload byte closes the frame
        logic [7:0]  value;     // command code on start, payload byte otherwise
        logic [15:0] len;       // payload length, start only
    } t_cmd;

endpackage

/* hdl/cfbsx_front.sv */
// ----------------------------------------------------------------------------
// cfbsx_front: input front end
// Accepts input transactions, tracks the open frame and the payload bytes
// still expected, drops stray payload bytes and queues start and data
// commands for the back end.
// ----------------------------------------------------------------------------
module cfbsx_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_action,
    input  logic [7:0]          i_command,
    input  logic [15:0]         i_payload_length,
    input  logic [7:0]          i_data_byte,
    input  logic                i_q_full,
    output logic                o_q_push,
    output cfbsx_pkg::t_cmd     o_q_cmd
);

    logic        r_open;
    logic        n_open;
    logic [15:0] r_left;
    logic [15:0] n_left;
    logic        accept;
    logic        is_start;

    assign accept   = i_push && !i_q_full;
    assign is_start = (i_action == cfbsx_pkg::ACT_START);

    // Classify the transaction: starts always queue, data only inside a frame
    always_comb begin
        n_open   = r_open;
        n_left   = r_left;
        o_q_push = 1'b0;
        o_q_cmd.is_start = is_start;
        o_q_cmd.last     = (r_left == 16'd1);
        o_q_cmd.value    = is_start ? i_command : i_data_byte;
        o_q_cmd.len      = i_payload_length;
        if (accept) begin
            if (is_start) begin
                o_q_push = 1'b1;
                n_left   = i_payload_length;
                n_open   = (i_payload_length != 16'd0);
            end else if (r_open) begin
                o_q_push = 1'b1;
                n_left   = r_left - 16'd1;
                if (r_left == 16'd1) begin
                    n_open = 1'b0;
                end
            end
        end
    end

    // Frame tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 16'd0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule

/* hdl/cfbsx_queue.sv */
// ----------------------------------------------------------------------------
// cfbsx_queue: command queue between front and back end
// Small first-in first-out buffer of command records.
// ----------------------------------------------------------------------------
module cfbsx_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cfbsx_pkg::t_cmd     i_wdata,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output cfbsx_pkg::t_cmd     o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cfbsx_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

/* hdl/cfbsx_back.sv */
// ----------------------------------------------------------------------------
// cfbsx_back: frame byte sequencer
// Expands queued commands into frame bytes: header on start, echo on data,
// sum and XOR trailer at frame end. Keeps the running checks and drives the
// output register.
// ----------------------------------------------------------------------------
module cfbsx_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  cfbsx_pkg::t_cmd     i_q_cmd,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_out_byte,
    output logic                o_frame_end
);

    typedef enum logic [6:0] {
        B_FETCH = 7'b0000001,
        B_LLO   = 7'b0000010,
        B_LHI   = 7'b0000100,
        B_MARK  = 7'b0001000,
        B_CMD   = 7'b0010000,
        B_SUM   = 7'b0100000,
        B_XOR   = 7'b1000000
    } t_bstate;

    t_bstate     r_state;
    t_bstate     n_state;
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    logic [7:0]  r_xor;
    logic [7:0]  n_xor;
    logic [15:0] r_len;
    logic [7:0]  r_cmd;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_end;
    logic        can_emit;
    logic        emit;
    logic        checked;
    logic        latch;
    logic [7:0]  emit_byte;
    logic        emit_end;

    // Output register takes a new byte when empty or being drained
    assign can_emit    = !r_out_valid || i_pop;
    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_out_end;

    // Sequencer: one frame byte per cycle while the output register can take one
    always_comb begin
        n_state   = r_state;
        emit      = 1'b0;
        checked   = 1'b0;
        latch     = 1'b0;
        emit_byte = 8'h00;
        emit_end  = 1'b0;
        o_q_pop   = 1'b0;
        if (can_emit) begin
            case (r_state)
                B_FETCH: begin
                    if (!i_q_empty) begin
                        o_q_pop = 1'b1;
                        emit    = 1'b1;
                        if (i_q_cmd.is_start) begin
                            latch     = 1'b1;
                            emit_byte = cfbsx_pkg::FRAME_HEAD;
                            n_state   = B_LLO;
                        end else begin
                            checked   = 1'b1;
                            emit_byte = i_q_cmd.value;
                            if (i_q_cmd.last) begin
                                n_state = B_SUM;
                            end
                        end
                    end
                end
                B_LLO: begin
                    emit      = 1'b1;
                    checked   = 1'b1;
                    emit_byte = r_len[7:0];
                    n_state   = B_LHI;
                end
                B_LHI: begin
                    emit      = 1'b1;
                    checked   = 1'b1;
                    emit_byte = r_len[15:8];
                    n_state   = B_MARK;
                end
                B_MARK: begin
                    emit      = 1'b1;
                    checked   = 1'b1;
                    emit_byte = cfbsx_pkg::FRAME_MARK;
                    n_state   = B_CMD;
                end
                B_CMD: begin
                    emit      = 1'b1;
                    checked   = 1'b1;
                    emit_byte = r_cmd;
                    n_state   = (r_len == 16'd0) ? B_SUM : B_FETCH;
                end
                B_SUM: begin
                    emit      = 1'b1;
                    emit_byte = r_sum;
                    n_state   = B_XOR;
                end
                B_XOR: begin
                    emit      = 1'b1;
                    emit_byte = r_xor;
                    emit_end  = 1'b1;
                    n_state   = B_FETCH;
                end
                default: begin
                    n_state = B_FETCH;
                end
            endcase
        end
    end

    // Running checks, cleared by a frame start
    always_comb begin
        n_sum = r_sum;
        n_xor = r_xor;
        if (latch) begin
            n_sum = 8'h00;
            n_xor = 8'h00;
        end else if (checked) begin
            n_sum = r_sum + emit_byte;
            n_xor = r_xor ^ emit_byte;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_FETCH;
            r_sum       <= 8'h00;
            r_xor       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_xor   <= n_xor;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (latch) begin
            r_len <= i_q_cmd.len;
            r_cmd <= i_q_cmd.value;
        end
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_end  <= emit_end;
        end
    end

endmodule

/* hdl/command_frame_builder_sum_xor.sv */
// ----------------------------------------------------------------------------
// command_frame_builder_sum_xor: serial command frame builder
// Builds frames of 0x79, length low/high, 0x58, command, payload bytes,
// 8-bit sum and 8-bit XOR over every byte after 0x79.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-----------------------------------
//  input     | in        | i_push / o_full    | i_action, i_command,
//            |           |                    | i_payload_length, i_data_byte
//  result    | out       | o_empty / i_pop    | o_out_byte, o_frame_end
//
//  Unless the result stalls, the back end emits one frame byte per cycle; a start
//  gives header, length, mark and command bytes (and the trailer with an empty
//  payload), a closing payload byte also the trailer. The queue absorbs input
//  during header and trailer bursts; o_full rises only once it holds QUEUE_DEPTH
//  commands. Reset is synchronous and clears the frame state, queue and output
//  register. A stalled result holds its byte; the queue takes input until full.
// ----------------------------------------------------------------------------
module command_frame_builder_sum_xor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_action,
    input  logic [7:0]  i_command,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end
);

    cfbsx_pkg::t_cmd wr_cmd;
    cfbsx_pkg::t_cmd rd_cmd;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;

    assign o_full = q_full;

    // Front end: accept and classify
    cfbsx_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .i_action         (i_action),
        .i_command        (i_command),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_cmd          (wr_cmd)
    );

    // Command queue
    cfbsx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (wr_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rdata (rd_cmd)
    );

    // Back end: byte sequencer and output register
    cfbsx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (rd_cmd),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule
